>>> hdl/finite_difference_first_derivative_assert.svh
// assertion macros for the finite difference derivative block
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef FINITE_DIFFERENCE_FIRST_DERIVATIVE_ASSERT_SVH
`define FINITE_DIFFERENCE_FIRST_DERIVATIVE_ASSERT_SVH

// same-cycle implication
`define FDFD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FDFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/fdfd_pkg.sv
// shared constants, types and stencil table of the finite difference derivative
// no dependencies
package fdfd_pkg;

  localparam int unsigned SAMPLE_WIDTH = 32;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned IDX_W        = 16;
  localparam int unsigned ST_W         = 2;
  localparam int unsigned COEF_W       = 7;
  localparam int unsigned ACC_W        = SAMPLE_WIDTH + COEF_W;
  localparam int unsigned MAG_W        = ACC_W - 1;
  localparam int unsigned DVD_W        = MAG_W + FRAC_BITS + 2;
  localparam int unsigned DVS_W        = MAG_W + 1;
  localparam int unsigned DIV_CNT_W    = $clog2(SAMPLE_WIDTH);
  localparam int unsigned WIN_DEPTH    = 5;
  localparam int unsigned WIN_SEL_W    = $clog2(WIN_DEPTH);
  localparam int unsigned NUM_STEPS    = 4;
  localparam int unsigned MAC_STEPS    = 6;
  localparam int unsigned STEP_W       = $clog2(MAC_STEPS);
  localparam int unsigned JOB_N        = 5;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_SAT   = 2'd1,
    ST_ZERO  = 2'd2,
    ST_SHORT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    JOB_START = 3'd0,
    JOB_TWOA  = 3'd1,
    JOB_MID   = 3'd2,
    JOB_TWOB  = 3'd3,
    JOB_END   = 3'd4
  } job_e;

  typedef struct packed {
    logic                        use_x;
    logic [WIN_SEL_W-1:0]        sel;
    logic signed [COEF_W-1:0]    coef;
  } term_t;

  typedef struct packed {
    logic                        done;
    status_e                     status;
    logic [SAMPLE_WIDTH-1:0]     value;
  } div_rsp_t;

  function automatic term_t mk_term(logic use_x, int unsigned sel, int coef);
    term_t t;
    t.use_x = use_x;
    t.sel   = WIN_SEL_W'(sel);
    t.coef  = COEF_W'(coef);
    return t;
  endfunction

  // numerator terms in steps 0..3, spacing terms in steps 4 and 5
  function automatic term_t term_of(job_e job, logic [STEP_W-1:0] step);
    term_t t;
    t = '0;
    unique case (job)
      JOB_START: begin
        unique case (step)
          0: t = mk_term(1'b0, 1, -48);
          1: t = mk_term(1'b0, 2, 59);
          2: t = mk_term(1'b0, 3, -8);
          3: t = mk_term(1'b0, 4, -3);
          4: t = mk_term(1'b1, 2, 34);
          default: t = mk_term(1'b1, 1, -34);
        endcase
      end
      JOB_TWOA: begin
        unique case (step)
          0: t = mk_term(1'b0, 1, -1);
          1: t = mk_term(1'b0, 3, 1);
          2, 3: t = mk_term(1'b0, 0, 0);
          4: t = mk_term(1'b1, 2, 2);
          default: t = mk_term(1'b1, 1, -2);
        endcase
      end
      JOB_MID: begin
        unique case (step)
          0: t = mk_term(1'b0, 0, 1);
          1: t = mk_term(1'b0, 1, -8);
          2: t = mk_term(1'b0, 3, 8);
          3: t = mk_term(1'b0, 4, -1);
          4: t = mk_term(1'b1, 4, 3);
          default: t = mk_term(1'b1, 0, -3);
        endcase
      end
      JOB_TWOB: begin
        unique case (step)
          0: t = mk_term(1'b0, 2, -1);
          1: t = mk_term(1'b0, 4, 1);
          2, 3: t = mk_term(1'b0, 0, 0);
          4: t = mk_term(1'b1, 4, 2);
          default: t = mk_term(1'b1, 3, -2);
        endcase
      end
      JOB_END: begin
        unique case (step)
          0: t = mk_term(1'b0, 1, 3);
          1: t = mk_term(1'b0, 2, 8);
          2: t = mk_term(1'b0, 3, -59);
          3: t = mk_term(1'b0, 4, 48);
          4: t = mk_term(1'b1, 4, 34);
          default: t = mk_term(1'b1, 3, -34);
        endcase
      end
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

>>> hdl/fdfd_if.sv
// sample and result channel interfaces of the finite difference derivative
// depends on fdfd_pkg
interface fdfd_smp_if;
  import fdfd_pkg::*;
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] f_value;
  logic signed [SAMPLE_WIDTH-1:0] x_value;
  logic                           last;
  modport source (output valid, f_value, x_value, last, input ready);
  modport sink (input valid, f_value, x_value, last, output ready);
endinterface

interface fdfd_res_if;
  import fdfd_pkg::*;
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] derivative;
  logic [IDX_W-1:0]               sample_index;
  logic [ST_W-1:0]                status;
  logic                           end_of_series;
  modport source (output valid, derivative, sample_index, status, end_of_series,
                  input ready);
  modport sink (input valid, derivative, sample_index, status, end_of_series,
                output ready);
endinterface

>>> hdl/fdfd_div.sv
// rounded fixed point quotient num / den, one quotient bit per cycle, with saturation
// depends on fdfd_pkg
module fdfd_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [fdfd_pkg::ACC_W-1:0] num_i,
  input  logic signed [fdfd_pkg::ACC_W-1:0] den_i,
  output fdfd_pkg::div_rsp_t                rsp_o
);
  import fdfd_pkg::*;

  localparam logic [2:0] D_IDLE  = 3'd0;
  localparam logic [2:0] D_ABS   = 3'd1;
  localparam logic [2:0] D_FORM  = 3'd2;
  localparam logic [2:0] D_CHECK = 3'd3;
  localparam logic [2:0] D_RUN   = 3'd4;
  localparam logic [2:0] D_FIN   = 3'd5;

  logic [2:0]                     state_q, state_d;
  logic signed [ACC_W-1:0]        num_q, num_d, den_q, den_d;
  logic signed [ACC_W-1:0]        num_abs, den_abs;
  logic [MAG_W-1:0]               an_q, an_d, ad_q, ad_d;
  logic                           neg_q, neg_d;
  logic [DVD_W-1:0]               dvd_q, dvd_d, hi;
  logic [DVS_W-1:0]               dvs_q, dvs_d, rem_q, rem_d;
  logic [SAMPLE_WIDTH-1:0]        lo_q, lo_d, quo_q, quo_d;
  logic [DIV_CNT_W-1:0]           cnt_q, cnt_d;
  status_e                        st_q, st_d;
  logic [DVS_W:0]                 trial, diff;
  logic                           ge;
  logic [SAMPLE_WIDTH-1:0]        lim_pos, lim_neg;
  logic                           over;

  assign num_abs = num_q[ACC_W-1] ? -num_q : num_q;
  assign den_abs = den_q[ACC_W-1] ? -den_q : den_q;
  assign hi      = dvd_q >> SAMPLE_WIDTH;
  assign trial   = {rem_q, lo_q[SAMPLE_WIDTH-1]};
  assign diff    = trial - {1'b0, dvs_q};
  assign ge      = trial >= {1'b0, dvs_q};
  assign lim_pos = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  assign lim_neg = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  assign over    = neg_q ? (quo_q > lim_neg) : (quo_q > lim_pos);

  always_comb begin
    state_d = state_q;
    num_d   = num_q;
    den_d   = den_q;
    an_d    = an_q;
    ad_d    = ad_q;
    neg_d   = neg_q;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    lo_d    = lo_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    st_d    = st_q;
    unique case (state_q)
      D_IDLE: begin
        if (start_i) begin
          num_d   = num_i;
          den_d   = den_i;
          state_d = D_ABS;
        end
      end
      D_ABS: begin
        an_d    = num_abs[MAG_W-1:0];
        ad_d    = den_abs[MAG_W-1:0];
        neg_d   = num_q[ACC_W-1] ^ den_q[ACC_W-1];
        state_d = D_FORM;
      end
      D_FORM: begin
        dvd_d   = DVD_W'({an_q, {(FRAC_BITS+1){1'b0}}}) + DVD_W'(ad_q);
        dvs_d   = {ad_q, 1'b0};
        state_d = D_CHECK;
      end
      D_CHECK: begin
        if (dvs_q == '0) begin
          st_d    = ST_ZERO;
          state_d = D_FIN;
        end else if (hi >= DVD_W'(dvs_q)) begin
          st_d    = ST_SAT;
          state_d = D_FIN;
        end else begin
          st_d    = ST_OK;
          rem_d   = hi[DVS_W-1:0];
          lo_d    = dvd_q[SAMPLE_WIDTH-1:0];
          cnt_d   = DIV_CNT_W'(SAMPLE_WIDTH - 1);
          state_d = D_RUN;
        end
      end
      D_RUN: begin
        rem_d = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        lo_d  = lo_q << 1;
        quo_d = {quo_q[SAMPLE_WIDTH-2:0], ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = D_FIN;
        end
      end
      D_FIN: begin
        state_d = D_IDLE;
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    an_q  <= an_d;
    ad_q  <= ad_d;
    neg_q <= neg_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    lo_q  <= lo_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
    st_q  <= st_d;
  end

  always_comb begin
    rsp_o.done   = (state_q == D_FIN);
    rsp_o.status = ST_OK;
    rsp_o.value  = '0;
    unique case (st_q)
      ST_ZERO: begin
        rsp_o.status = ST_ZERO;
      end
      ST_SAT: begin
        rsp_o.status = ST_SAT;
        rsp_o.value  = neg_q ? lim_neg : lim_pos;
      end
      default: begin
        if (over) begin
          rsp_o.status = ST_SAT;
          rsp_o.value  = neg_q ? lim_neg : lim_pos;
        end else begin
          rsp_o.value  = neg_q ? (SAMPLE_WIDTH'(0) - quo_q) : quo_q;
        end
      end
    endcase
  end

endmodule

>>> hdl/finite_difference_first_derivative.sv
// fourth order (second order next to the ends) finite difference first derivative over a stream of (f, x) samples
// depends on fdfd_pkg, fdfd_if, fdfd_div and finite_difference_first_derivative_assert.svh
// one result runs 6 multiply-accumulate steps, a divider launch, the divider and a load
// a new sample is taken only once every result of the last one is loaded and the window is moved on
// the restoring divider (one quotient bit a cycle) sets the rate; zero spacing or saturation ends it early
// rst_ni clears the sample window, the count and all handshake state asynchronously
`include "finite_difference_first_derivative_assert.svh"

module finite_difference_first_derivative (
  input  logic        clk_i,
  input  logic        rst_ni,
  fdfd_smp_if.sink    smp_i,
  fdfd_res_if.source  res_o
);
  import fdfd_pkg::*;

  localparam logic [2:0] T_IDLE   = 3'd0;
  localparam logic [2:0] T_MAC    = 3'd1;
  localparam logic [2:0] T_LAUNCH = 3'd2;
  localparam logic [2:0] T_DIVW   = 3'd3;
  localparam logic [2:0] T_EMIT   = 3'd4;
  localparam logic [2:0] T_SHORT  = 3'd5;
  localparam logic [2:0] T_WRAP   = 3'd6;

  logic [2:0]                     state_q, state_d;
  logic signed [SAMPLE_WIDTH-1:0] fw_q [WIN_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] fw_d [WIN_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] xw_q [WIN_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] xw_d [WIN_DEPTH];
  logic [IDX_W-1:0]               cnt_q, cnt_d;
  logic                           last_q, last_d;
  logic [JOB_N-1:0]               mask_q, mask_d, start_mask, rest_mask, job_bit;
  job_e                           job_q, job_d;
  logic [STEP_W-1:0]              step_q, step_d;
  logic signed [ACC_W-1:0]        num_q, num_d, den_q, den_d, prod;
  logic signed [SAMPLE_WIDTH-1:0] res_val_q, res_val_d;
  status_e                        res_st_q, res_st_d;
  term_t                          term;
  logic signed [COEF_W-1:0]       coef;
  logic signed [SAMPLE_WIDTH-1:0] opnd;
  logic [IDX_W-1:0]               job_idx;
  logic                           div_start;
  div_rsp_t                       div_rsp;

  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_val_q;
  logic [IDX_W-1:0]               out_idx_q;
  status_e                        out_st_q;
  logic                           out_eos_q;
  logic                           out_free, out_load;
  logic signed [SAMPLE_WIDTH-1:0] load_val;
  logic [IDX_W-1:0]               load_idx;
  status_e                        load_st;
  logic                           load_eos;

  function automatic job_e first_job(logic [JOB_N-1:0] m);
    priority if (m[JOB_START]) return JOB_START;
    else if (m[JOB_TWOA]) return JOB_TWOA;
    else if (m[JOB_MID]) return JOB_MID;
    else if (m[JOB_TWOB]) return JOB_TWOB;
    else return JOB_END;
  endfunction

  fdfd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .rsp_o   (div_rsp)
  );

  // shared multiply-accumulate operand and coefficient
  assign term = term_of(job_q, step_q);
  assign coef = term.coef;
  assign opnd = term.use_x ? xw_q[term.sel] : fw_q[term.sel];
  assign prod = opnd * coef;

  always_comb begin
    start_mask            = '0;
    start_mask[JOB_START] = (cnt_q == IDX_W'(3));
    start_mask[JOB_TWOA]  = (cnt_q == IDX_W'(3));
    start_mask[JOB_MID]   = (cnt_q >= IDX_W'(4));
    start_mask[JOB_TWOB]  = smp_i.last;
    start_mask[JOB_END]   = smp_i.last;
  end

  assign job_bit   = JOB_N'(1) << job_q;
  assign rest_mask = mask_q & ~job_bit;

  always_comb begin
    unique case (job_q)
      JOB_START: job_idx = '0;
      JOB_TWOA:  job_idx = IDX_W'(1);
      JOB_MID:   job_idx = cnt_q - IDX_W'(2);
      JOB_TWOB:  job_idx = cnt_q - IDX_W'(1);
      default:   job_idx = cnt_q;
    endcase
  end

  assign out_free = !out_valid_q || res_o.ready;

  always_comb begin
    state_d   = state_q;
    fw_d      = fw_q;
    xw_d      = xw_q;
    cnt_d     = cnt_q;
    last_d    = last_q;
    mask_d    = mask_q;
    job_d     = job_q;
    step_d    = step_q;
    num_d     = num_q;
    den_d     = den_q;
    res_val_d = res_val_q;
    res_st_d  = res_st_q;
    div_start = 1'b0;
    out_load  = 1'b0;
    load_val  = '0;
    load_idx  = job_idx;
    load_st   = res_st_q;
    load_eos  = 1'b0;
    unique case (state_q)
      T_IDLE: begin
        if (smp_i.valid) begin
          fw_d[WIN_DEPTH-1] = smp_i.f_value;
          xw_d[WIN_DEPTH-1] = smp_i.x_value;
          last_d = smp_i.last;
          mask_d = start_mask;
          job_d  = first_job(start_mask);
          step_d = '0;
          num_d  = '0;
          den_d  = '0;
          if (smp_i.last && (cnt_q < IDX_W'(3))) begin
            state_d = T_SHORT;
          end else if (start_mask != '0) begin
            state_d = T_MAC;
          end else begin
            state_d = T_WRAP;
          end
        end
      end
      T_MAC: begin
        if (step_q < STEP_W'(NUM_STEPS)) begin
          num_d = num_q + prod;
        end else begin
          den_d = den_q + prod;
        end
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(MAC_STEPS - 1)) begin
          state_d = T_LAUNCH;
        end
      end
      T_LAUNCH: begin
        div_start = 1'b1;
        state_d   = T_DIVW;
      end
      T_DIVW: begin
        if (div_rsp.done) begin
          res_val_d = div_rsp.value;
          res_st_d  = div_rsp.status;
          state_d   = T_EMIT;
        end
      end
      T_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          load_val = res_val_q;
          load_eos = (job_q == JOB_END);
          mask_d   = rest_mask;
          if (rest_mask != '0) begin
            job_d   = first_job(rest_mask);
            step_d  = '0;
            num_d   = '0;
            den_d   = '0;
            state_d = T_MAC;
          end else begin
            state_d = T_WRAP;
          end
        end
      end
      T_SHORT: begin
        if (out_free) begin
          out_load = 1'b1;
          load_idx = cnt_q;
          load_st  = ST_SHORT;
          load_eos = 1'b1;
          state_d  = T_WRAP;
        end
      end
      T_WRAP: begin
        if (last_q) begin
          fw_d  = '{default: '0};
          xw_d  = '{default: '0};
          cnt_d = '0;
        end else begin
          for (int i = 0; i < WIN_DEPTH - 1; i++) begin
            fw_d[i] = fw_q[i+1];
            xw_d[i] = xw_q[i+1];
          end
          if (cnt_q != '1) begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        state_d = T_IDLE;
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      fw_q        <= '{default: '0};
      xw_q        <= '{default: '0};
      cnt_q       <= '0;
      last_q      <= 1'b0;
      mask_q      <= '0;
      job_q       <= JOB_START;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fw_q    <= fw_d;
      xw_q    <= xw_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      mask_q  <= mask_d;
      job_q   <= job_d;
      step_q  <= step_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    num_q     <= num_d;
    den_q     <= den_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    if (out_load) begin
      out_val_q <= load_val;
      out_idx_q <= load_idx;
      out_st_q  <= load_st;
      out_eos_q <= load_eos;
    end
  end

  assign smp_i.ready         = (state_q == T_IDLE);
  assign res_o.valid         = out_valid_q;
  assign res_o.derivative    = out_val_q;
  assign res_o.sample_index  = out_idx_q;
  assign res_o.status        = out_st_q;
  assign res_o.end_of_series = out_eos_q;

  `FDFD_ASSERT_IMPL(a_div_done_in_wait, div_rsp.done, state_q == T_DIVW, "divider done outside wait")
  `FDFD_ASSERT_IMPL(a_job_pending, state_q == T_MAC || state_q == T_LAUNCH || state_q == T_DIVW, mask_q[job_q], "working on a job that is not pending")
  `FDFD_ASSERT_NEXT(a_end_job_last, state_q == T_EMIT && out_free && job_q == JOB_END, state_q == T_WRAP && mask_q == '0, "jobs left after end of series")
  `FDFD_ASSERT_IMPL(a_short_early, state_q == T_SHORT, last_q && cnt_q < IDX_W'(3), "short series error on a long series")

endmodule
